// ===== hw/rtl/gpt_pkg.sv =====
package gpt_pkg;

    // number of compare channels handled by default
    localparam int COMPARE_CHANNELS_DEFAULT = 4;

    // counter width when the narrow mode is selected
    localparam int NARROW_BITS = 16;

    // operation codes carried in the input word's tuser
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // register byte offsets
    localparam logic [7:0] OFS_CR1   = 8'h00;
    localparam logic [7:0] OFS_CR2   = 8'h04;
    localparam logic [7:0] OFS_SMCR  = 8'h08;
    localparam logic [7:0] OFS_DIER  = 8'h0C;
    localparam logic [7:0] OFS_SR    = 8'h10;
    localparam logic [7:0] OFS_EGR   = 8'h14;
    localparam logic [7:0] OFS_CCMR1 = 8'h18;
    localparam logic [7:0] OFS_CCMR2 = 8'h1C;
    localparam logic [7:0] OFS_CCER  = 8'h20;
    localparam logic [7:0] OFS_CNT   = 8'h24;
    localparam logic [7:0] OFS_PSC   = 8'h28;
    localparam logic [7:0] OFS_ARR   = 8'h2C;
    localparam logic [7:0] OFS_CCR1  = 8'h34;
    localparam logic [7:0] OFS_CCR2  = 8'h38;
    localparam logic [7:0] OFS_CCR3  = 8'h3C;
    localparam logic [7:0] OFS_CCR4  = 8'h40;
    localparam logic [7:0] OFS_DCR   = 8'h48;
    localparam logic [7:0] OFS_OR    = 8'h50;

    // write masks and the interrupt mask
    localparam logic [15:0] MASK_CR1  = 16'h039F;
    localparam logic [15:0] MASK_CR2  = 16'h00F8;
    localparam logic [15:0] MASK_SMCR = 16'hFFF7;
    localparam logic [15:0] MASK_DIER = 16'h5F5F;
    localparam logic [15:0] MASK_EGR  = 16'h005F;
    localparam logic [15:0] MASK_CCER = 16'hBBBB;
    localparam logic [15:0] MASK_IRQ  = 16'h005F;

    // register bit positions
    localparam int CR1_CEN  = 0;
    localparam int CR1_UDIS = 1;
    localparam int CR1_DIR  = 4;
    localparam int CR1_ARPE = 7;
    localparam int EGR_UG   = 0;
    localparam int SR_UIF   = 0;
    localparam int CCMR_PE_LO = 3;
    localparam int CCMR_PE_HI = 11;

    // one input word
    typedef struct packed {
        op_t         operation;
        logic [7:0]  reg_offset;
        logic [31:0] write_data;
    } item_t;

    // one result word
    typedef struct packed {
        logic [31:0] read_data;
        logic        bus_error;
        logic        irq_level;
    } result_t;

endpackage

// ===== hw/rtl/gpt_core.sv =====
module gpt_core #(
    parameter int CompareChannels = gpt_pkg::COMPARE_CHANNELS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             counter_is_16bit,
    input  logic             item_valid,
    input  gpt_pkg::item_t   item,
    output gpt_pkg::result_t result
);
    import gpt_pkg::*;

    // register file
    logic [15:0] cr1_reg, cr1_next;
    logic [15:0] cr2_reg, cr2_next;
    logic [15:0] smcr_reg, smcr_next;
    logic [15:0] dier_reg, dier_next;
    logic [15:0] sr_reg, sr_next;
    logic [15:0] egr_reg, egr_next;
    logic [15:0] ccmr_reg [2];
    logic [15:0] ccmr_next [2];
    logic [15:0] ccer_reg, ccer_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] psc_reg, psc_next;
    logic [31:0] psc_shadow_reg, psc_shadow_next;
    logic [31:0] psc_count_reg, psc_count_next;
    logic [31:0] arr_reg, arr_next;
    logic [31:0] arr_shadow_reg, arr_shadow_next;
    logic [31:0] ccr_reg [4];
    logic [31:0] ccr_next [4];
    logic [31:0] ccr_shadow_reg [4];
    logic [31:0] ccr_shadow_next [4];
    logic [31:0] dcr_reg, dcr_next;
    logic [31:0] or_reg, or_next;
    logic        running_reg, running_next;

    // shadow values an update event would load
    logic [3:0]  preload;
    logic [31:0] upd_arr_shadow;
    logic [31:0] upd_ccr_shadow [4];
    logic [31:0] size_mask;

    always_comb begin
        preload[0] = ccmr_reg[0][CCMR_PE_LO];
        preload[1] = ccmr_reg[0][CCMR_PE_HI];
        preload[2] = ccmr_reg[1][CCMR_PE_LO];
        preload[3] = ccmr_reg[1][CCMR_PE_HI];
        upd_arr_shadow = cr1_reg[CR1_ARPE] ? arr_reg : arr_shadow_reg;
        for (int ch = 0; ch < 4; ch++) begin
            upd_ccr_shadow[ch] = preload[ch] ? ccr_reg[ch] : ccr_shadow_reg[ch];
        end
        size_mask = counter_is_16bit ? {{(32 - NARROW_BITS){1'b0}}, {NARROW_BITS{1'b1}}}
                                     : '1;
    end

    // next state and result for the word in the input register
    logic [31:0] rd;
    logic        err;
    logic        update_ev;
    logic        wrap;
    logic [31:0] cnt_tmp;
    logic [31:0] wval;
    logic [15:0] eg;
    logic [7:0]  ccr_off;
    logic [1:0]  ccr_sel;

    always_comb begin
        cr1_next        = cr1_reg;
        cr2_next        = cr2_reg;
        smcr_next       = smcr_reg;
        dier_next       = dier_reg;
        sr_next         = sr_reg;
        egr_next        = egr_reg;
        ccmr_next       = ccmr_reg;
        ccer_next       = ccer_reg;
        cnt_next        = cnt_reg;
        psc_next        = psc_reg;
        psc_shadow_next = psc_shadow_reg;
        psc_count_next  = psc_count_reg;
        arr_next        = arr_reg;
        arr_shadow_next = arr_shadow_reg;
        ccr_next        = ccr_reg;
        ccr_shadow_next = ccr_shadow_reg;
        dcr_next        = dcr_reg;
        or_next         = or_reg;
        running_next    = running_reg;
        rd        = '0;
        err       = 1'b0;
        update_ev = 1'b0;
        wrap      = 1'b0;
        cnt_tmp   = cnt_reg;
        wval      = item.write_data & size_mask;
        eg        = item.write_data[15:0] & MASK_EGR;
        ccr_off   = item.reg_offset - OFS_CCR1;
        ccr_sel   = ccr_off[3:2];

        if (item_valid) begin
            case (item.operation)
                // register read
                OP_READ: begin
                    case (item.reg_offset)
                        OFS_CR1:   rd = {16'h0, cr1_reg};
                        OFS_CR2:   rd = {16'h0, cr2_reg};
                        OFS_SMCR:  rd = {16'h0, smcr_reg};
                        OFS_DIER:  rd = {16'h0, dier_reg};
                        OFS_SR:    rd = {16'h0, sr_reg};
                        OFS_EGR:   rd = {16'h0, egr_reg};
                        OFS_CCMR1: rd = {16'h0, ccmr_reg[0]};
                        OFS_CCMR2: rd = {16'h0, ccmr_reg[1]};
                        OFS_CCER:  rd = {16'h0, ccer_reg};
                        OFS_CNT:   rd = cnt_reg;
                        OFS_PSC:   rd = psc_reg;
                        OFS_ARR:   rd = arr_reg;
                        OFS_CCR1, OFS_CCR2, OFS_CCR3, OFS_CCR4: rd = ccr_reg[ccr_sel];
                        OFS_DCR:   rd = dcr_reg;
                        OFS_OR:    rd = or_reg;
                        default:   err = 1'b1;
                    endcase
                end
                // register write
                OP_WRITE: begin
                    case (item.reg_offset)
                        OFS_CR1: begin
                            cr1_next     = item.write_data[15:0] & MASK_CR1;
                            running_next = item.write_data[CR1_CEN];
                        end
                        OFS_CR2:   cr2_next = item.write_data[15:0] & MASK_CR2;
                        OFS_SMCR:  smcr_next = item.write_data[15:0] & MASK_SMCR;
                        OFS_DIER:  dier_next = item.write_data[15:0] & MASK_DIER;
                        OFS_SR:    sr_next = sr_reg & item.write_data[15:0];
                        OFS_EGR: begin
                            if (eg[EGR_UG]) begin
                                update_ev      = 1'b1;
                                cnt_next       = cr1_reg[CR1_DIR] ? upd_arr_shadow : '0;
                                sr_next[SR_UIF] = 1'b1;
                                psc_count_next = '0;
                                eg[EGR_UG]     = 1'b0;
                            end
                            for (int ch = 0; ch < CompareChannels; ch++) begin
                                if (eg[ch + 1]) begin
                                    sr_next[ch + 1] = 1'b1;
                                    eg[ch + 1]      = 1'b0;
                                end
                            end
                            egr_next = eg;
                        end
                        OFS_CCMR1: ccmr_next[0] = item.write_data[15:0];
                        OFS_CCMR2: ccmr_next[1] = item.write_data[15:0];
                        OFS_CCER:  ccer_next = item.write_data[15:0] & MASK_CCER;
                        OFS_CNT:   cnt_next = wval;
                        OFS_PSC:   psc_next = item.write_data;
                        OFS_ARR: begin
                            arr_next = wval;
                            if (wval == '0) begin
                                running_next = 1'b0;
                            end
                            if (!cr1_reg[CR1_ARPE]) begin
                                arr_shadow_next = wval;
                            end
                        end
                        OFS_CCR1, OFS_CCR2, OFS_CCR3, OFS_CCR4: begin
                            ccr_next[ccr_sel] = wval;
                            if (!preload[ccr_sel]) begin
                                ccr_shadow_next[ccr_sel] = wval;
                            end
                        end
                        OFS_DCR:   dcr_next = item.write_data;
                        OFS_OR:    or_next = item.write_data;
                        default:   err = 1'b1;
                    endcase
                end
                // kernel clock tick
                OP_TICK: begin
                    if (running_reg) begin
                        if (psc_count_reg >= psc_shadow_reg) begin
                            psc_count_next = '0;
                            if (cr1_reg[CR1_DIR]) begin
                                cnt_tmp = (cnt_reg - 32'd1) & size_mask;
                                wrap    = (cnt_tmp == '0);
                            end else begin
                                cnt_tmp = (cnt_reg + 32'd1) & size_mask;
                                wrap    = (cnt_tmp == arr_shadow_reg);
                            end
                            update_ev = wrap && !cr1_reg[CR1_UDIS];
                            if (update_ev) begin
                                sr_next[SR_UIF] = 1'b1;
                            end
                            if (wrap) begin
                                if (cr1_reg[CR1_DIR]) begin
                                    cnt_tmp = update_ev ? upd_arr_shadow : arr_shadow_reg;
                                end else begin
                                    cnt_tmp = '0;
                                end
                            end
                            cnt_next = cnt_tmp;
                            for (int ch = 0; ch < CompareChannels; ch++) begin
                                if (cnt_tmp == (update_ev ? upd_ccr_shadow[ch]
                                                          : ccr_shadow_reg[ch])) begin
                                    sr_next[ch + 1] = 1'b1;
                                end
                            end
                        end else begin
                            psc_count_next = psc_count_reg + 32'd1;
                        end
                    end
                end
                default: ;
            endcase

            // shadow copy on an update event
            if (update_ev) begin
                psc_shadow_next = psc_reg;
                arr_shadow_next = upd_arr_shadow;
                ccr_shadow_next = upd_ccr_shadow;
            end
        end

        result.read_data = rd;
        result.bus_error = err;
        result.irq_level = |(sr_next & dier_next & MASK_IRQ);
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr1_reg        <= '0;
            cr2_reg        <= '0;
            smcr_reg       <= '0;
            dier_reg       <= '0;
            sr_reg         <= '0;
            egr_reg        <= '0;
            ccmr_reg       <= '{default: '0};
            ccer_reg       <= '0;
            cnt_reg        <= '0;
            psc_reg        <= '0;
            psc_shadow_reg <= '0;
            psc_count_reg  <= '0;
            arr_reg        <= '0;
            arr_shadow_reg <= '0;
            ccr_reg        <= '{default: '0};
            ccr_shadow_reg <= '{default: '0};
            dcr_reg        <= '0;
            or_reg         <= '0;
            running_reg    <= 1'b0;
        end else begin
            cr1_reg        <= cr1_next;
            cr2_reg        <= cr2_next;
            smcr_reg       <= smcr_next;
            dier_reg       <= dier_next;
            sr_reg         <= sr_next;
            egr_reg        <= egr_next;
            ccmr_reg       <= ccmr_next;
            ccer_reg       <= ccer_next;
            cnt_reg        <= cnt_next;
            psc_reg        <= psc_next;
            psc_shadow_reg <= psc_shadow_next;
            psc_count_reg  <= psc_count_next;
            arr_reg        <= arr_next;
            arr_shadow_reg <= arr_shadow_next;
            ccr_reg        <= ccr_next;
            ccr_shadow_reg <= ccr_shadow_next;
            dcr_reg        <= dcr_next;
            or_reg         <= or_next;
            running_reg    <= running_next;
        end
    end

endmodule

// ===== hw/rtl/general_purpose_timer_registers.sv =====
// General purpose up/down timer with a register map, driven by a word stream.
// Each input word on the s_ channel is a register read, a register write or
// one kernel clock tick (selected by s_tuser). Every input word produces
// exactly one result word on the m_ channel carrying the read data, a bus
// error flag for unmapped offsets and the interrupt level after the word.
// The cfg_ channel sets the 16-bit counter mode; write it only while the
// block is idle.
// A word accepted into the input register is processed once the result register
// is free or being drained, and its result is then held in the result register.
// Throughput: one word per cycle while the receiver takes results, set by the
// single register-file update stage between the input and result registers.
// Reset (aresetn low, synchronous) clears all timer registers, the width mode,
// the counter and both channel registers' valid flags; the counter is stopped.
// When the receiver stalls, the result register holds its word and the
// input register takes one more word, then s_tready drops until the result
// is taken.
module general_purpose_timer_registers #(
    parameter int COMPARE_CHANNELS = gpt_pkg::COMPARE_CHANNELS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,        // counter_is_16bit
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,         // [7:0] reg_offset, [39:8] write_data
    input  logic [1:0]  s_tuser,         // [1:0] operation
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,         // [31:0] read_data, [32] irq_level, zero pad
    output logic        m_tuser          // [0] bus_error
);
    import gpt_pkg::*;

    logic    counter_is_16bit_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    advance;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_is_16bit_reg <= 1'b0;
        end else if (cfg_valid) begin
            counter_is_16bit_reg <= cfg_data;
        end
    end

    // handshake: process when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation  <= op_t'(s_tuser);
            in_item_reg.reg_offset <= s_tdata[7:0];
            in_item_reg.write_data <= s_tdata[39:8];
        end
    end

    gpt_core #(
        .CompareChannels(COMPARE_CHANNELS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .counter_is_16bit(counter_is_16bit_reg),
        .item_valid      (advance),
        .item            (in_item_reg),
        .result          (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg.irq_level, out_result_reg.read_data};
    assign m_tuser  = out_result_reg.bus_error;

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpt_pkg::*;

    // operation code the block ignores
    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam int CHANNELS = COMPARE_CHANNELS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_SLACK = 6;
    localparam int LONG_HOLD = 80;
    localparam int PHASE_WORDS = 450;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // [7:0] reg_offset, [39:8] write_data
    logic [1:0]  s_tuser = '0;      // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] read_data, [32] irq_level, zero pad
    logic        m_tuser;           // [0] bus_error

    general_purpose_timer_registers dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // results still owed by the block
    result_t timer_results [$];

    // run limit
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, timer_results.size());
            $display("FAIL general_purpose_timer_registers");
            $finish;
        end
    end

    // timer state as the testbench sees it
    bit          narrow_mode = 1'b0;
    logic [31:0] ctrl1 = '0, ctrl2 = '0, slave_ctrl = '0, irq_enable = '0;
    logic [31:0] flags = '0, event_gen = '0, cc_enable = '0;
    logic [31:0] ccmr [2] = '{default: '0};
    logic [31:0] count = '0, presc = '0, presc_shadow = '0, presc_ticks = '0;
    logic [31:0] reload = '0, reload_shadow = '0;
    logic [31:0] compare [4] = '{default: '0};
    logic [31:0] compare_shadow [4] = '{default: '0};
    logic [31:0] dma_ctrl = '0, option_reg = '0;
    bit          counting = 1'b0;

    int mismatches = 0;
    int reads = 0, writes = 0, ticks = 0, idles = 0, busy_words = 0;
    int counter_steps = 0, update_events = 0, checked = 0;

    logic [7:0] mapped_offsets [18] = '{
        OFS_CR1, OFS_CR2, OFS_SMCR, OFS_DIER, OFS_SR, OFS_EGR, OFS_CCMR1, OFS_CCMR2,
        OFS_CCER, OFS_CNT, OFS_PSC, OFS_ARR, OFS_CCR1, OFS_CCR2, OFS_CCR3, OFS_CCR4,
        OFS_DCR, OFS_OR
    };
    logic [7:0] compare_offsets [4] = '{OFS_CCR1, OFS_CCR2, OFS_CCR3, OFS_CCR4};

    function automatic logic [31:0] width_mask();
        return narrow_mode ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    endfunction

    function automatic bit channel_preloaded(int ch);
        return ccmr[ch >> 1][(ch & 1) ? CCMR_PE_HI : CCMR_PE_LO];
    endfunction

    // copy of preload registers into their shadows
    function automatic void apply_update();
        presc_shadow = presc;
        if (ctrl1[CR1_ARPE])
            reload_shadow = reload;
        for (int ch = 0; ch < 4; ch++)
            if (channel_preloaded(ch))
                compare_shadow[ch] = compare[ch];
    endfunction

    function automatic void on_wrap();
        if (!ctrl1[CR1_UDIS]) begin
            apply_update();
            flags[SR_UIF] = 1'b1;
            update_events++;
        end
    endfunction

    // one counter step, then compare matches
    function automatic void step_counter();
        logic [31:0] m;
        m = width_mask();
        counter_steps++;
        if (ctrl1[CR1_DIR]) begin
            count = (count - 32'd1) & m;
            if (count == 0) begin
                on_wrap();
                count = reload_shadow;
            end
        end else begin
            count = (count + 32'd1) & m;
            if (count == reload_shadow) begin
                on_wrap();
                count = '0;
            end
        end
        for (int ch = 0; ch < CHANNELS && ch < 4; ch++)
            if (count == compare_shadow[ch])
                flags[ch + 1] = 1'b1;
    endfunction

    function automatic void kernel_tick();
        if (!counting)
            return;
        if (presc_ticks >= presc_shadow) begin
            presc_ticks = '0;
            step_counter();
        end else begin
            presc_ticks++;
        end
    endfunction

    function automatic bit read_register(input logic [7:0] ofs, output logic [31:0] value);
        case (ofs)
            OFS_CR1:   value = ctrl1;
            OFS_CR2:   value = ctrl2;
            OFS_SMCR:  value = slave_ctrl;
            OFS_DIER:  value = irq_enable;
            OFS_SR:    value = flags;
            OFS_EGR:   value = event_gen;
            OFS_CCMR1: value = ccmr[0];
            OFS_CCMR2: value = ccmr[1];
            OFS_CCER:  value = cc_enable;
            OFS_CNT:   value = count;
            OFS_PSC:   value = presc;
            OFS_ARR:   value = reload;
            OFS_CCR1, OFS_CCR2, OFS_CCR3, OFS_CCR4:
                value = compare[(ofs - OFS_CCR1) >> 2];
            OFS_DCR:   value = dma_ctrl;
            OFS_OR:    value = option_reg;
            default: begin
                value = '0;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic bit write_register(input logic [7:0] ofs, input logic [31:0] wd);
        int ch;
        case (ofs)
            OFS_CR1: begin
                ctrl1 = wd & MASK_CR1;
                counting = ctrl1[CR1_CEN];
            end
            OFS_CR2:   ctrl2 = wd & MASK_CR2;
            OFS_SMCR:  slave_ctrl = wd & MASK_SMCR;
            OFS_DIER:  irq_enable = wd & MASK_DIER;
            // status bits can only be cleared by software
            OFS_SR:    flags = flags & wd;
            OFS_EGR: begin
                event_gen = wd & MASK_EGR;
                if (event_gen[EGR_UG]) begin
                    apply_update();
                    count = ctrl1[CR1_DIR] ? reload_shadow : '0;
                    flags[SR_UIF] = 1'b1;
                    presc_ticks = '0;
                    event_gen[EGR_UG] = 1'b0;
                end
                for (ch = 0; ch < CHANNELS && ch < 4; ch++)
                    if (event_gen[ch + 1]) begin
                        flags[ch + 1] = 1'b1;
                        event_gen[ch + 1] = 1'b0;
                    end
            end
            OFS_CCMR1: ccmr[0] = wd & 32'h0000_FFFF;
            OFS_CCMR2: ccmr[1] = wd & 32'h0000_FFFF;
            OFS_CCER:  cc_enable = wd & MASK_CCER;
            OFS_CNT:   count = wd & width_mask();
            OFS_PSC:   presc = wd;
            OFS_ARR: begin
                reload = wd & width_mask();
                if (reload == 0)
                    counting = 1'b0;
                if (!ctrl1[CR1_ARPE])
                    reload_shadow = reload;
            end
            OFS_CCR1, OFS_CCR2, OFS_CCR3, OFS_CCR4: begin
                ch = (ofs - OFS_CCR1) >> 2;
                compare[ch] = wd & width_mask();
                if (!channel_preloaded(ch))
                    compare_shadow[ch] = compare[ch];
            end
            OFS_DCR:   dma_ctrl = wd;
            OFS_OR:    option_reg = wd;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // result of one word, updating the timer state
    function automatic result_t timer_predict(logic [1:0] op, logic [7:0] ofs,
                                              logic [31:0] wd);
        result_t r;
        logic [31:0] value;
        r = '0;
        case (op)
            OP_READ: begin
                r.bus_error = !read_register(ofs, value);
                r.read_data = value;
            end
            OP_WRITE: r.bus_error = !write_register(ofs, wd);
            OP_TICK:  kernel_tick();
            default: ;
        endcase
        r.irq_level = |(flags & irq_enable & MASK_IRQ);
        return r;
    endfunction

    // sender pacing
    int  sender_stretch = 0;
    bit  sender_steady = 1'b0;

    task automatic send_word(input logic [1:0] op, input logic [7:0] ofs,
                             input logic [31:0] wd, input bit typed, input result_t want);
        int gap;
        result_t predicted;
        if (sender_stretch == 0) begin
            sender_stretch = $urandom_range(20, 60);
            sender_steady = ($urandom_range(0, 3) == 0);
        end
        sender_stretch--;
        gap = sender_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {wd, ofs};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = timer_predict(op, ofs, wd);
        timer_results.push_back(typed ? want : predicted);
        case (op)
            OP_READ:  reads++;
            OP_WRITE: writes++;
            OP_TICK:  ticks++;
            default:  idles++;
        endcase
        if (op != OP_IDLE)
            busy_words++;
    endtask

    task automatic send(input logic [1:0] op, input logic [7:0] ofs, input logic [31:0] wd);
        send_word(op, ofs, wd, 1'b0, '0);
    endtask

    // stop offering and wait until every owed result has come
    task automatic drain();
        s_tvalid <= 1'b0;
        while (timer_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic set_width_mode(input bit narrow);
        cfg_valid <= 1'b1;
        cfg_data <= narrow;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        narrow_mode = narrow;
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off on request
    int  hold_request = 0;
    int  recv_stretch = 0;
    bit  recv_steady = 1'b0;

    initial begin
        int stall;
        result_t got;
        result_t want;
        wait (aresetn);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                if (recv_stretch == 0) begin
                    recv_stretch = $urandom_range(20, 60);
                    recv_steady = ($urandom_range(0, 3) == 0);
                end
                recv_stretch--;
                stall = recv_steady ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.read_data = m_tdata[31:0];
            got.irq_level = m_tdata[32];
            got.bus_error = m_tuser;
            if (timer_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing owed: rd=%h err=%b irq=%b",
                             $realtime, got.read_data, got.bus_error, got.irq_level);
            end else begin
                want = timer_results.pop_front();
                checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch rd=%h/%h err=%b/%b irq=%b/%b (exp/got)",
                                 $realtime, want.read_data, got.read_data,
                                 want.bus_error, got.bus_error,
                                 want.irq_level, got.irq_level);
                end
            end
        end
    end

    // bring-up sequence: reset values, errors, masks, one short count
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ofs;
        logic [31:0] data;
        logic        typed;
        logic [31:0] rd;
        logic        err;
        logic        irq;
    } script_row_t;

    localparam int SCRIPT_ROWS = 26;
    script_row_t bringup_script [SCRIPT_ROWS] = '{
        '{OP_READ,  OFS_CR1,   32'h0,         1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_READ,  8'h30,     32'h0,         1'b1, 32'h0,         1'b1, 1'b0},
        '{OP_WRITE, 8'hFF,     32'hFFFF_FFFF, 1'b1, 32'h0,         1'b1, 1'b0},
        '{OP_IDLE,  8'hFF,     32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_TICK,  OFS_CR1,   32'h0,         1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_CR1,   32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_READ,  OFS_CR1,   32'h0,         1'b1, 32'h0000_039F, 1'b0, 1'b0},
        '{OP_WRITE, OFS_CR1,   32'h0,         1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_DIER,  32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_READ,  OFS_DIER,  32'h0,         1'b1, 32'h0000_5F5F, 1'b0, 1'b0},
        '{OP_WRITE, OFS_PSC,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_ARR,   32'h3,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_CCR1,  32'h2,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_EGR,   32'h1,         1'b1, 32'h0,         1'b0, 1'b1},
        '{OP_WRITE, OFS_SR,    32'h0,         1'b1, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_CR1,   32'h1,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_TICK,  8'h00,     32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_TICK,  8'h00,     32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_TICK,  8'h00,     32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_READ,  OFS_SR,    32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_CR1,   32'h13,        1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_TICK,  8'h00,     32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_WRITE, OFS_EGR,   32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_READ,  OFS_EGR,   32'h0,         1'b1, 32'h0000_0040, 1'b0, 1'b1},
        '{OP_WRITE, OFS_ARR,   32'h0,         1'b0, 32'h0,         1'b0, 1'b0},
        '{OP_TICK,  8'h00,     32'h0,         1'b0, 32'h0,         1'b0, 1'b0}
    };

    function automatic logic [7:0] any_register();
        return mapped_offsets[$urandom_range(0, 17)];
    endfunction

    // one word inside a running sequence, mostly ticks
    task automatic send_running_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            send(OP_TICK, 8'($urandom), $urandom);
        else if (r < 72)
            send(OP_READ, $urandom_range(0, 1) ? ($urandom_range(0, 1) ? OFS_CNT : OFS_SR)
                                              : any_register(), $urandom);
        else if (r < 80)
            send(OP_WRITE, OFS_SR, $urandom_range(0, 1) ? ~(32'h1 << $urandom_range(0, 4))
                                                       : $urandom);
        else if (r < 85)
            send(OP_WRITE, OFS_CNT, $urandom_range(0, 12));
        else if (r < 90)
            send(OP_WRITE, compare_offsets[$urandom_range(0, 3)], $urandom_range(0, 12));
        else if (r < 94)
            send(OP_WRITE, $urandom_range(0, 1) ? OFS_ARR : OFS_PSC, $urandom_range(0, 12));
        else if (r < 97)
            send(OP_WRITE, OFS_EGR, $urandom);
        else
            send(OP_WRITE, any_register(), $urandom);
    endtask

    // program a short count, start it, then let it run with traffic around it
    task automatic send_count_sequence();
        int len;
        send(OP_WRITE, OFS_CR1, 32'h0);
        if ($urandom_range(0, 1))
            send(OP_WRITE, $urandom_range(0, 1) ? OFS_CCMR1 : OFS_CCMR2, $urandom);
        send(OP_WRITE, OFS_PSC, $urandom_range(0, 3));
        send(OP_WRITE, OFS_ARR, ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom_range(1, 12));
        repeat ($urandom_range(1, 3))
            send(OP_WRITE, compare_offsets[$urandom_range(0, 3)], $urandom_range(0, 12));
        if ($urandom_range(0, 1))
            send(OP_WRITE, OFS_DIER, $urandom);
        if ($urandom_range(0, 2) == 0)
            send(OP_WRITE, OFS_CNT, $urandom_range(0, 12));
        if ($urandom_range(0, 1))
            send(OP_WRITE, OFS_EGR, ($urandom & 32'h1E) | 32'h1);
        // CEN on, random direction and preload, update disable now and then
        send(OP_WRITE, OFS_CR1, ($urandom & (($urandom_range(0, 3) == 0) ? 32'h392 : 32'h390))
                                | 32'h1);
        len = $urandom_range(10, 40);
        repeat (len) send_running_word();
    endtask

    task automatic run_random(input int quota);
        int start;
        bit held;
        bit paused;
        start = busy_words;
        held = 1'b0;
        paused = 1'b0;
        while (busy_words - start < quota) begin
            if ($urandom_range(0, 3) != 0) begin
                send_count_sequence();
            end else begin
                repeat ($urandom_range(3, 10))
                    send(2'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? any_register() : 8'($urandom_range(0, 255)),
                         $urandom);
            end
            // receiver backs off for a while, sender keeps offering
            if (!held && busy_words - start >= quota / 2) begin
                hold_request = LONG_HOLD;
                held = 1'b1;
            end
            // sender waits for the pipeline to empty once
            if (!paused && busy_words - start >= (3 * quota) / 4) begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    initial begin
        result_t want;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_width_mode(1'b0);
        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            want.read_data = bringup_script[i].rd;
            want.bus_error = bringup_script[i].err;
            want.irq_level = bringup_script[i].irq;
            send_word(bringup_script[i].op, bringup_script[i].ofs, bringup_script[i].data,
                      bringup_script[i].typed, want);
        end
        drain();

        // alternate counter widths between random phases
        set_width_mode(1'b1);
        run_random(PHASE_WORDS);
        set_width_mode(1'b0);
        run_random(PHASE_WORDS);
        set_width_mode(1'b1);
        run_random(PHASE_WORDS);
        set_width_mode(1'b0);
        run_random(PHASE_WORDS);

        $display("covered %0d reads, %0d writes, %0d ticks, %0d ignored words in both widths",
                 reads, writes, ticks, idles);
        $display("counter stepped %0d times with %0d update events; %0d results checked",
                 counter_steps, update_events, checked);
        if (mismatches == 0) begin
            $display("PASS general_purpose_timer_registers");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL general_purpose_timer_registers");
        end
        $finish;
    end
endmodule

// ===== general_purpose_timer_registers.f =====
hw/rtl/gpt_pkg.sv
hw/rtl/gpt_core.sv
hw/rtl/general_purpose_timer_registers.sv
tb/tb.sv
